// ===== hw/rtl/lzss_pkg.sv =====
// lzss_pkg: shared types and constants of the lzss stream decoder
// used by lzss_ring and lzss_stream_decoder; depends on nothing

package lzss_pkg;

  // history ring geometry
  localparam int unsigned RING_DEPTH = 4096;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
  localparam int unsigned MAX_MATCH  = 18;
  localparam int unsigned MIN_MATCH  = 3;
  localparam int unsigned CNT_W      = $clog2(MAX_MATCH + 1);

  typedef logic [RING_AW-1:0] ring_addr_t;
  typedef logic [RING_AW:0]   ring_fill_t;
  typedef logic [CNT_W-1:0]   match_cnt_t;

  localparam ring_addr_t WRITE_START = ring_addr_t'(RING_DEPTH - MAX_MATCH);
  localparam ring_fill_t FILL_FULL   = ring_fill_t'(RING_DEPTH);
  localparam logic [7:0] FILL_BYTE   = 8'h20;

  // what the next compressed byte means
  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_ITEM  = 2'd1,
    PH_MATCH = 2'd2
  } phase_t;

  // copy sequencer
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } seq_state_t;

  // requests from the sequencer to the ring
  typedef struct packed {
    logic       rd_en;
    ring_addr_t rd_addr;
    logic       wr_en;
    logic [7:0] wr_data;
    logic       clear;
  } ring_cmd_t;

endpackage

// ===== hw/rtl/lzss_in_if.sv =====
// lzss_in_if: compressed byte channel with valid/ready handshake
// stand-alone, no dependencies

interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       block_last;

  modport source (output valid, output in_byte, output block_last, input ready);
  modport sink   (input valid, input in_byte, input block_last, output ready);
endinterface

// ===== hw/rtl/lzss_out_if.sv =====
// lzss_out_if: decompressed byte channel with valid/ready handshake
// stand-alone, no dependencies

interface lzss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== hw/rtl/lzss_ring.sv =====
// lzss_ring: 4096 x 8 history ring with write pointer and fill count
// depends on lzss_pkg

module lzss_ring (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lzss_pkg::ring_cmd_t  cmd,
  output logic [7:0]           rd_byte
);

  logic [7:0]           mem [lzss_pkg::RING_DEPTH];
  logic [7:0]           rd_data_r;
  logic                 rd_hit_r;
  lzss_pkg::ring_addr_t wpos_r;
  lzss_pkg::ring_fill_t fill_r;
  lzss_pkg::ring_addr_t rd_off;

  // entries are written in order from the start position, so an entry
  // holds real data exactly when its distance from the start is below the fill
  assign rd_off = cmd.rd_addr - lzss_pkg::WRITE_START;

  // storage, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wpos_r] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
    end
  end

  // written-entry flag follows the read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_hit_r <= 1'b0;
    end else if (cmd.rd_en) begin
      rd_hit_r <= ({1'b0, rd_off} < fill_r);
    end
  end

  // write pointer and fill count, both back to start on clear
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      wpos_r <= lzss_pkg::WRITE_START;
      fill_r <= '0;
    end else if (cmd.wr_en) begin
      wpos_r <= wpos_r + 1'b1;
      if (fill_r != lzss_pkg::FILL_FULL) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // never-written entries read as spaces
  assign rd_byte = rd_hit_r ? rd_data_r : lzss_pkg::FILL_BYTE;

endmodule

// ===== hw/rtl/lzss_stream_decoder.sv =====
// lzss_stream_decoder: top level, byte decoder and match copy sequencer
// depends on lzss_pkg, lzss_in_if, lzss_out_if and lzss_ring

// Decodes one compressed block into bytes. Flag bytes, match head bytes
// and literals are taken while the output register is free; a literal is
// emitted straight into the output register. A match of L bytes (3 to 18)
// holds the input off from its second byte until its copy ends: every
// copied byte is one read of the history ring through its single
// registered read port and one emit that writes it back, so overlapping
// copies see their own output. No clearing pass is needed after reset or
// after the last item of a block: a fill count marks which ring entries
// have been written and the rest read as spaces.

module lzss_stream_decoder (
  input  logic              clk,
  input  logic              rst_n,
  lzss_in_if.sink           in_ch,
  lzss_out_if.source        out_ch
);

  lzss_pkg::seq_state_t state_r, state_nxt;
  lzss_pkg::phase_t     phase_r, phase_nxt;
  logic [8:0]           flag_r, flag_nxt;
  logic [7:0]           low_r, low_nxt;
  lzss_pkg::ring_addr_t src_r, src_nxt;
  lzss_pkg::match_cnt_t cnt_r, cnt_nxt;
  logic                 last_r, last_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic                 out_last_r, out_last_nxt;

  lzss_pkg::ring_cmd_t  ring_cmd;
  logic [7:0]           ring_byte;
  logic                 in_go;
  logic                 out_free;
  logic                 emit_go;
  logic [8:0]           flag_shr;
  lzss_pkg::phase_t     phase_done;

  lzss_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (ring_cmd),
    .rd_byte (ring_byte)
  );

  // handshakes
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == lzss_pkg::S_IDLE) && out_free;
  assign in_go        = in_ch.valid && in_ch.ready;
  assign emit_go      = (state_r == lzss_pkg::S_EMIT) && out_free;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.run_last = out_last_r;

  // flag state after an item completes
  assign flag_shr   = {1'b0, flag_r[8:1]};
  assign phase_done = (flag_shr <= 9'd1) ? lzss_pkg::PH_FLAG : lzss_pkg::PH_ITEM;

  // decoder and copy sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    flag_nxt      = flag_r;
    low_nxt       = low_r;
    src_nxt       = src_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    ring_cmd      = '0;

    unique case (state_r)
      lzss_pkg::S_IDLE: begin
        if (in_go) begin
          unique case (phase_r)
            lzss_pkg::PH_ITEM: begin
              if (flag_r[0]) begin
                // literal, emitted and stored
                out_valid_nxt    = 1'b1;
                out_byte_nxt     = in_ch.in_byte;
                out_last_nxt     = 1'b1;
                ring_cmd.wr_en   = 1'b1;
                ring_cmd.wr_data = in_ch.in_byte;
                flag_nxt         = flag_shr;
                phase_nxt        = phase_done;
              end else begin
                low_nxt   = in_ch.in_byte;
                phase_nxt = lzss_pkg::PH_MATCH;
              end
            end
            lzss_pkg::PH_MATCH: begin
              // match head complete, start the copy
              src_nxt   = {in_ch.in_byte[7:4], low_r};
              cnt_nxt   = lzss_pkg::match_cnt_t'(in_ch.in_byte[3:0])
                        + lzss_pkg::match_cnt_t'(lzss_pkg::MIN_MATCH);
              last_nxt  = in_ch.block_last;
              state_nxt = lzss_pkg::S_READ;
            end
            default: begin
              flag_nxt  = {1'b1, in_ch.in_byte};
              phase_nxt = lzss_pkg::PH_ITEM;
            end
          endcase
          // end of block outside a copy: back to reset at once
          if (in_ch.block_last && phase_r != lzss_pkg::PH_MATCH) begin
            flag_nxt       = '0;
            phase_nxt      = lzss_pkg::PH_FLAG;
            low_nxt        = '0;
            ring_cmd.clear = 1'b1;
          end
        end
      end
      lzss_pkg::S_READ: begin
        ring_cmd.rd_en   = 1'b1;
        ring_cmd.rd_addr = src_r;
        state_nxt        = lzss_pkg::S_EMIT;
      end
      lzss_pkg::S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt    = 1'b1;
          out_byte_nxt     = ring_byte;
          out_last_nxt     = (cnt_r == lzss_pkg::match_cnt_t'(1));
          ring_cmd.wr_en   = 1'b1;
          ring_cmd.wr_data = ring_byte;
          src_nxt          = src_r + 1'b1;
          cnt_nxt          = cnt_r - 1'b1;
          if (cnt_r == lzss_pkg::match_cnt_t'(1)) begin
            state_nxt = lzss_pkg::S_IDLE;
            flag_nxt  = flag_shr;
            phase_nxt = phase_done;
            if (last_r) begin
              flag_nxt       = '0;
              phase_nxt      = lzss_pkg::PH_FLAG;
              low_nxt        = '0;
              ring_cmd.clear = 1'b1;
            end
          end else begin
            state_nxt = lzss_pkg::S_READ;
          end
        end
      end
      default: begin
        state_nxt = lzss_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lzss_pkg::S_IDLE;
      phase_r     <= lzss_pkg::PH_FLAG;
      flag_r      <= '0;
      low_r       <= '0;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      flag_r      <= flag_nxt;
      low_r       <= low_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (state_r == lzss_pkg::S_IDLE))
    else $error("input ready during a copy");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != lzss_pkg::S_IDLE) |->
      (cnt_r != '0 && cnt_r <= lzss_pkg::match_cnt_t'(lzss_pkg::MAX_MATCH)))
    else $error("copy count out of range");

  a_read_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lzss_pkg::S_READ) |=> (state_r == lzss_pkg::S_EMIT))
    else $error("ring read not followed by emit");

  a_copy_end: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && cnt_r == lzss_pkg::match_cnt_t'(1)) |=>
      (state_r == lzss_pkg::S_IDLE && out_valid_r && out_last_r))
    else $error("copy end not marked on last byte");
`endif

endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking bench for lzss_stream_decoder with its own decoder model
// depends on lzss_pkg, lzss_in_if, lzss_out_if and the decoder rtl

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT     = 38;
  localparam int RANDOM_ITEMS = 480;
  localparam int HOLD_AT      = 120;   // items taken before the long receiver hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int CALM_FROM    = 250;   // window of items with no idling on either side
  localparam int CALM_TO      = 340;
  localparam int DRAIN_CYCLES = 60;    // longest match copy is 18 bytes
  // ~480 items, each up to 18 bytes, each byte a ring read and an emit plus random stalls
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic       pause;
    logic       last;
    logic [7:0] data;
  } comp_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
  } plain_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  lzss_in_if  in_ch ();
  lzss_out_if out_ch ();

  lzss_stream_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // decoder model state
  logic [8:0]           flag_bits;
  lzss_pkg::phase_t     phase;
  logic [7:0]           match_low;
  lzss_pkg::ring_addr_t wr_pos;
  logic [7:0]           history [lzss_pkg::RING_DEPTH];
  plain_byte_t          plain_expected[$];

  comp_item_t  compressed_stream[$];
  int          n_queued = 0;
  int          n_taken = 0;
  int          n_fail = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          cycles = 0;

  wire calm = (n_taken >= CALM_FROM) && (n_taken < CALM_TO);

  function automatic void clear_decoder();
    flag_bits = '0;
    phase     = lzss_pkg::PH_FLAG;
    match_low = '0;
    wr_pos    = lzss_pkg::WRITE_START;
    foreach (history[i]) history[i] = lzss_pkg::FILL_BYTE;
  endfunction

  function automatic void next_item();
    flag_bits = flag_bits >> 1;
    phase     = (flag_bits <= 9'd1) ? lzss_pkg::PH_FLAG : lzss_pkg::PH_ITEM;
  endfunction

  // decode one compressed byte and queue the plain bytes it yields
  function automatic void decode_byte(logic [7:0] b, logic last);
    logic [7:0]           run[$];
    lzss_pkg::ring_addr_t src;
    int                   len;
    int                   k;
    case (phase)
      lzss_pkg::PH_ITEM: begin
        if (flag_bits[0]) begin
          run.push_back(b);
          history[wr_pos] = b;
          wr_pos++;
          next_item();
        end else begin
          match_low = b;
          phase     = lzss_pkg::PH_MATCH;
        end
      end
      lzss_pkg::PH_MATCH: begin
        src = {b[7:4], match_low};
        len = int'(b[3:0]) + int'(lzss_pkg::MIN_MATCH);
        // byte by byte, so an overlapping copy sees what it has just written
        for (k = 0; k < len; k++) begin
          run.push_back(history[src]);
          history[wr_pos] = history[src];
          wr_pos++;
          src++;
        end
        next_item();
      end
      default: begin
        flag_bits = {1'b1, b};
        phase     = lzss_pkg::PH_ITEM;
      end
    endcase
    foreach (run[i]) plain_expected.push_back('{data: run[i], run_last: (i == run.size() - 1)});
    if (last) clear_decoder();
  endfunction

  function automatic void queue_byte(logic [7:0] b, logic last);
    compressed_stream.push_back('{pause: 1'b0, last: last, data: b});
    n_queued++;
  endfunction

  // sender waits here until every plain byte has come out
  function automatic void queue_pause();
    compressed_stream.push_back('{pause: 1'b1, last: 1'b0, data: 8'h00});
  endfunction

  // one compressed block: mostly well formed, some cut short, some pure noise
  function automatic void queue_block();
    logic [7:0]           blk[$];
    logic [7:0]           flags;
    lzss_pkg::ring_addr_t pos;
    lzss_pkg::ring_addr_t src;
    logic [3:0]           len_code;
    int                   n_items;
    int                   roll;
    int                   cut;
    int                   i;
    pos   = lzss_pkg::WRITE_START;
    flags = 8'h00;
    roll  = $urandom_range(0, 99);
    if (roll < 12) begin
      repeat ($urandom_range(1, 12)) blk.push_back(8'($urandom));
    end else begin
      n_items = $urandom_range(1, 30);
      for (i = 0; i < n_items; i++) begin
        if (i % 8 == 0) begin
          case ($urandom_range(0, 3))
            0: flags = 8'hFF;
            1: flags = 8'h00;
            default: flags = 8'($urandom);
          endcase
          blk.push_back(flags);
        end
        if (flags[i % 8]) begin
          blk.push_back(8'($urandom));
          pos++;
        end else begin
          // mostly close behind the write position so copies overlap
          if ($urandom_range(0, 9) < 6)
            src = pos - lzss_pkg::ring_addr_t'($urandom_range(0, 20));
          else src = lzss_pkg::ring_addr_t'($urandom);
          len_code = 4'($urandom);
          blk.push_back(src[7:0]);
          blk.push_back({src[11:8], len_code});
          pos += lzss_pkg::ring_addr_t'(len_code)
               + lzss_pkg::ring_addr_t'(lzss_pkg::MIN_MATCH);
        end
      end
      // broken block: end it early, often inside an item
      if (roll < 25) begin
        cut = $urandom_range(1, blk.size());
        while (blk.size() > cut) void'(blk.pop_back());
      end
    end
    foreach (blk[j]) queue_byte(blk[j], j == blk.size() - 1);
  endfunction

  // driver: offers queued items, predicts each one taken
  always @(posedge clk) begin : drive
    logic fire;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        decode_byte(in_ch.in_byte, in_ch.block_last);
        void'(compressed_stream.pop_front());
        n_taken <= n_taken + 1;
      end
      if (in_ch.valid && !fire) begin
        // keep the current item on the bus
      end else if (compressed_stream.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (compressed_stream[0].pause) begin
        in_ch.valid <= 1'b0;
        if (plain_expected.size() == 0 && !out_ch.valid) void'(compressed_stream.pop_front());
      end else if (!calm && hold_left == 0 && $urandom_range(0, 99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid      <= 1'b1;
        in_ch.in_byte    <= compressed_stream[0].data;
        in_ch.block_last <= compressed_stream[0].last;
      end
    end
  end

  // monitor: checks every plain byte against the oldest expectation
  always @(posedge clk) begin : watch
    plain_byte_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (plain_expected.size() == 0) begin
          $error("out_byte %02h arrived with nothing expected", out_ch.out_byte);
          n_fail++;
        end else begin
          want = plain_expected.pop_front();
          if (want.data != out_ch.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_ch.out_byte);
            n_fail++;
          end
          if (want.run_last != out_ch.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, out_ch.run_last);
            n_fail++;
          end
        end
      end
      // one long hold-off so the decoder backs up into its input
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && n_taken >= HOLD_AT) begin
        hold_done    <= 1'b1;
        hold_left    <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int n_directed;
    bit mid_pause;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.in_byte     = 8'h00;
    in_ch.block_last  = 1'b0;
    out_ch.ready      = 1'b0;
    mid_pause         = 1'b0;
    clear_decoder();

    // two literals at the byte extremes, then six matches
    queue_byte(8'h03, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    // longest match from the start position, overlapping its own output
    queue_byte(8'hEE, 1'b0);
    queue_byte(8'hFF, 1'b0);
    // shortest match from the bottom of the ring, which the long match wrapped into
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    // distance one: repeats the last byte
    queue_byte(8'h04, 1'b0);
    queue_byte(8'h02, 1'b0);
    // source wraps past the top of the ring
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hF0, 1'b0);
    // source equal to the write position
    queue_byte(8'h0D, 1'b0);
    queue_byte(8'h00, 1'b0);
    // block ends on a match head, the match is dropped
    queue_byte(8'h10, 1'b1);
    // block ends right after its flag byte
    queue_byte(8'h00, 1'b1);
    // block ends on a literal
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h5A, 1'b1);
    // fresh ring again: literal then a full match ending the block
    queue_byte(8'h01, 1'b0);
    queue_byte(8'hA5, 1'b0);
    queue_byte(8'hEE, 1'b0);
    queue_byte(8'hFF, 1'b1);
    n_directed = n_queued;
    queue_pause();

    while (n_queued < n_directed + RANDOM_ITEMS) begin
      queue_block();
      if (!mid_pause && n_queued > n_directed + RANDOM_ITEMS / 2) begin
        queue_pause();
        mid_pause = 1'b1;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (compressed_stream.size() != 0);
    do @(posedge clk); while (plain_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== lzss_stream_decoder.f =====
hw/rtl/lzss_pkg.sv
hw/rtl/lzss_in_if.sv
hw/rtl/lzss_out_if.sv
hw/rtl/lzss_ring.sv
hw/rtl/lzss_stream_decoder.sv
verif/testbench.sv
